/* rtl/wirc_pkg.sv */
// Shared types and constants for the windowed inversion rank counter.
// No dependencies; every other file in rtl/ imports this package.
package wirc_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int TOTAL_W    = 48;
	localparam int WSIZE_W    = 7;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;

	localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd64;

	// register index, taken from paddr[CFG_ADDR_W-1]
	localparam logic REG_WIN_LEN = 1'b0;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [TOTAL_W-1:0] total_t;
	typedef logic [WSIZE_W-1:0] wsize_t;

	function automatic total_t sat_add(input total_t acc, input total_t inc);
		logic [TOTAL_W:0] sum;
		sum = {1'b0, acc} + {1'b0, inc};
		return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
	endfunction

endpackage

/* rtl/wirc_if.sv */
// Valid/ready channel interfaces for samples in and totals out.
// Depends on wirc_pkg.
interface wirc_sample_if;
	import wirc_pkg::*;
	logic valid;
	logic ready;
	sample_t sample_value;
	modport source(output valid, output sample_value, input ready);
	modport sink(input valid, input sample_value, output ready);
endinterface

interface wirc_result_if;
	import wirc_pkg::*;
	logic valid;
	logic ready;
	total_t inversion_total;
	total_t pair_total;
	total_t rank_diff_total;
	modport source(output valid, output inversion_total, output pair_total,
		output rank_diff_total, input ready);
	modport sink(input valid, input inversion_total, input pair_total,
		input rank_diff_total, output ready);
endinterface

/* rtl/wirc_cfg.sv */
// APB-style register file holding the window length register.
// Depends on wirc_pkg.
module wirc_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [wirc_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [wirc_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [wirc_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready,
	output wirc_pkg::wsize_t                    win_len
);
	import wirc_pkg::*;

	wsize_t win_len_q;
	logic   sel_ws;
	logic   wr;

	assign pready = 1'b1;
	assign sel_ws = (paddr[CFG_ADDR_W-1] == REG_WIN_LEN);
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= WSIZE_RESET;
		end else if (wr && sel_ws) begin
			win_len_q <= pwdata[WSIZE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_ws) begin
			prdata = CFG_DATA_W'(win_len_q);
		end
	end

	assign win_len = win_len_q;

endmodule

/* rtl/wirc_cell.sv */
// One window position: holds a stored sample, its rank offset and square,
// and updates the token passing through to the next cell. Depends on wirc_pkg.
module wirc_cell #(
	parameter int MAX_WINDOW = 64,
	parameter int IDX = 0,
	localparam int PW = $clog2(MAX_WINDOW),
	localparam int IW = 2 * PW,
	localparam int SQW = 3 * PW
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic                    in_last,
	input  logic [PW-1:0]           in_pos,
	input  wirc_pkg::sample_t       in_value,
	input  logic signed [PW:0]      in_d,
	input  logic [2*PW-1:0]         in_sq,
	input  logic [PW-1:0]           in_inv,
	input  logic [IW-1:0]           in_invsum,
	input  logic [SQW-1:0]          in_sqsum,
	input  logic [IW-1:0]           in_pairs,
	output logic                    out_valid,
	output logic                    out_last,
	output logic [PW-1:0]           out_pos,
	output wirc_pkg::sample_t       out_value,
	output logic signed [PW:0]      out_d,
	output logic [2*PW-1:0]         out_sq,
	output logic [PW-1:0]           out_inv,
	output logic [IW-1:0]           out_invsum,
	output logic [SQW-1:0]          out_sqsum,
	output logic [IW-1:0]           out_pairs
);
	import wirc_pkg::*;

	localparam int XW = 2 * PW + 2;
	localparam logic [PW-1:0] MY_POS = PW'(IDX);

	sample_t               v_q;
	logic signed [PW:0]    d_q;
	logic [2*PW-1:0]       sq_q;
	logic [PW-1:0]         inv_q;

	logic                  past;
	logic                  hit;
	logic                  gt;
	logic [2*PW-1:0]       cell_sq_inc;
	logic [2*PW-1:0]       tok_sq_inc;

	logic signed [PW:0]    nx_d;
	logic [2*PW-1:0]       nx_sq;
	logic [PW-1:0]         nx_inv;
	logic [IW-1:0]         nx_invsum;
	logic [SQW-1:0]        nx_sqsum;

	assign past = in_valid && (in_pos > MY_POS);
	assign hit  = in_valid && (in_pos == MY_POS);
	assign gt   = v_q > in_value;

	// (d+1)^2 = d^2 + 2d + 1
	assign cell_sq_inc = (2*PW)'(XW'(sq_q) + XW'($signed({d_q, 1'b1})));
	assign tok_sq_inc  = (2*PW)'(XW'(in_sq) + XW'($signed({in_d, 1'b1})));

	always_comb begin
		nx_d      = in_d;
		nx_sq     = in_sq;
		nx_inv    = in_inv;
		nx_invsum = in_invsum;
		nx_sqsum  = in_sqsum;
		if (past) begin
			if (gt) begin
				nx_inv = in_inv + PW'(1);
			end else begin
				nx_d  = in_d + (PW+1)'(1);
				nx_sq = tok_sq_inc;
			end
			if (in_last) begin
				nx_invsum = in_invsum + IW'(inv_q);
				nx_sqsum  = in_sqsum + SQW'(gt ? cell_sq_inc : sq_q);
			end
		end else if (hit && in_last) begin
			nx_invsum = in_invsum + IW'(in_inv);
			nx_sqsum  = in_sqsum + SQW'(in_sq);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (hit) begin
				v_q   <= in_value;
				d_q   <= in_d;
				sq_q  <= in_sq;
				inv_q <= in_inv;
			end else if (past && gt) begin
				d_q  <= d_q + (PW+1)'(1);
				sq_q <= cell_sq_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_last   <= in_last;
			out_pos    <= in_pos;
			out_value  <= in_value;
			out_d      <= nx_d;
			out_sq     <= nx_sq;
			out_inv    <= nx_inv;
			out_invsum <= nx_invsum;
			out_sqsum  <= nx_sqsum;
			out_pairs  <= in_pairs;
		end
	end

endmodule

/* rtl/wirc_accum.sv */
// Saturating running totals and the result output register.
// Depends on wirc_pkg and wirc_if.
module wirc_accum #(
	parameter int MAX_WINDOW = 64,
	localparam int PW = $clog2(MAX_WINDOW),
	localparam int IW = 2 * PW,
	localparam int SQW = 3 * PW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tok_valid,
	input  logic               tok_last,
	input  logic [IW-1:0]      invsum,
	input  logic [SQW-1:0]     sqsum,
	input  logic [IW-1:0]      pairs,
	output logic               adv,
	wirc_result_if.source      result
);
	import wirc_pkg::*;

	logic   valid_q;
	total_t inv_acc_q;
	total_t pair_acc_q;
	total_t sq_acc_q;
	logic   close;

	assign adv   = !valid_q || result.ready;
	assign close = tok_valid && tok_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			inv_acc_q  <= '0;
			pair_acc_q <= '0;
			sq_acc_q   <= '0;
		end else if (adv) begin
			valid_q <= close;
			if (close) begin
				inv_acc_q  <= sat_add(inv_acc_q, TOTAL_W'(invsum));
				pair_acc_q <= sat_add(pair_acc_q, TOTAL_W'(pairs));
				sq_acc_q   <= sat_add(sq_acc_q, TOTAL_W'(sqsum));
			end
		end
	end

	assign result.valid           = valid_q;
	assign result.inversion_total = inv_acc_q;
	assign result.pair_total      = pair_acc_q;
	assign result.rank_diff_total = sq_acc_q;

endmodule

/* rtl/windowed_inversion_rank_counter_core.sv */
// Windowed inversion / rank displacement counter. Accepts one sample per cycle
// and runs it down a chain of MAX_WINDOW cells, one cell per cycle; a window's
// result becomes valid once the sample that closes it has passed the input
// register, the MAX_WINDOW cells and the output register. The whole chain
// holds while a result is waiting to be taken, and so does the input. The size
// register is read only as a sample is accepted; write it with the chain empty.
module windowed_inversion_rank_counter_core #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [wirc_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [wirc_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [wirc_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready,
	wirc_sample_if.sink                         sample,
	wirc_result_if.source                       result
);
	import wirc_pkg::*;

	localparam int PW  = $clog2(MAX_WINDOW);
	localparam int IW  = 2 * PW;
	localparam int SQW = 3 * PW;
	localparam int CW  = (PW + 1 > WSIZE_W) ? PW + 1 : WSIZE_W;

	wsize_t           win_len;
	logic             adv;
	logic             accept;

	logic [PW-1:0]    fill_q;
	logic [CW-1:0]    ws_ext;
	logic [CW-1:0]    size_eff;
	logic [CW-1:0]    count;
	logic             closing;
	logic [PW:0]      pos_p1;
	logic [2*PW-1:0]  pos_sq;
	logic [2*PW-1:0]  pos_prod;

	logic                 t_valid  [0:MAX_WINDOW];
	logic                 t_last   [0:MAX_WINDOW];
	logic [PW-1:0]        t_pos    [0:MAX_WINDOW];
	sample_t              t_value  [0:MAX_WINDOW];
	logic signed [PW:0]   t_d      [0:MAX_WINDOW];
	logic [2*PW-1:0]      t_sq     [0:MAX_WINDOW];
	logic [PW-1:0]        t_inv    [0:MAX_WINDOW];
	logic [IW-1:0]        t_invsum [0:MAX_WINDOW];
	logic [SQW-1:0]       t_sqsum  [0:MAX_WINDOW];
	logic [IW-1:0]        t_pairs  [0:MAX_WINDOW];

	logic                 valid_s1;
	logic                 last_s1;
	logic [PW-1:0]        pos_s1;
	sample_t              value_s1;
	logic signed [PW:0]   d_s1;
	logic [2*PW-1:0]      sq_s1;
	logic [IW-1:0]        pairs_s1;

	wirc_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.win_len     (win_len)
	);

	assign sample.ready = adv;
	assign accept       = sample.valid && adv;

	always_comb begin
		ws_ext = CW'(win_len);
		if (ws_ext < CW'(2)) begin
			size_eff = CW'(2);
		end else if (ws_ext > CW'(MAX_WINDOW)) begin
			size_eff = CW'(MAX_WINDOW);
		end else begin
			size_eff = ws_ext;
		end
	end

	assign count    = CW'(fill_q) + CW'(1);
	assign closing  = count >= size_eff;
	assign pos_p1   = (PW+1)'(fill_q) + (PW+1)'(1);
	assign pos_sq   = (2*PW)'(fill_q) * (2*PW)'(fill_q);
	assign pos_prod = (2*PW)'(fill_q) * (2*PW)'(pos_p1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= sample.valid;
			if (sample.valid) begin
				fill_q <= closing ? '0 : fill_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1  <= closing;
			pos_s1   <= fill_q;
			value_s1 <= sample.sample_value;
			d_s1     <= -$signed((PW+1)'(fill_q));
			sq_s1    <= pos_sq;
			pairs_s1 <= IW'(pos_prod[2*PW-1:1]);
		end
	end

	assign t_valid[0]  = valid_s1;
	assign t_last[0]   = last_s1;
	assign t_pos[0]    = pos_s1;
	assign t_value[0]  = value_s1;
	assign t_d[0]      = d_s1;
	assign t_sq[0]     = sq_s1;
	assign t_inv[0]    = '0;
	assign t_invsum[0] = '0;
	assign t_sqsum[0]  = '0;
	assign t_pairs[0]  = pairs_s1;

	for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
		wirc_cell #(
			.MAX_WINDOW (MAX_WINDOW),
			.IDX        (k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (adv),
			.in_valid   (t_valid[k]),
			.in_last    (t_last[k]),
			.in_pos     (t_pos[k]),
			.in_value   (t_value[k]),
			.in_d       (t_d[k]),
			.in_sq      (t_sq[k]),
			.in_inv     (t_inv[k]),
			.in_invsum  (t_invsum[k]),
			.in_sqsum   (t_sqsum[k]),
			.in_pairs   (t_pairs[k]),
			.out_valid  (t_valid[k+1]),
			.out_last   (t_last[k+1]),
			.out_pos    (t_pos[k+1]),
			.out_value  (t_value[k+1]),
			.out_d      (t_d[k+1]),
			.out_sq     (t_sq[k+1]),
			.out_inv    (t_inv[k+1]),
			.out_invsum (t_invsum[k+1]),
			.out_sqsum  (t_sqsum[k+1]),
			.out_pairs  (t_pairs[k+1])
		);
	end

	wirc_accum #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (t_valid[MAX_WINDOW]),
		.tok_last  (t_last[MAX_WINDOW]),
		.invsum    (t_invsum[MAX_WINDOW]),
		.sqsum     (t_sqsum[MAX_WINDOW]),
		.pairs     (t_pairs[MAX_WINDOW]),
		.adv       (adv),
		.result    (result)
	);

endmodule
